[hdl/epoch_quorum_vote_tracker_macros.svh]
// assertion macros shared by the vote tracker rtl
// no dependencies; included by files that carry concurrent checks
`ifndef EPOCH_QUORUM_VOTE_TRACKER_MACROS_SVH
`define EPOCH_QUORUM_VOTE_TRACKER_MACROS_SVH

// plain property checked on every rising edge outside reset
`define EQVT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("eqvt check failed");

// condition in one cycle implies expression in the next
`define EQVT_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("eqvt check failed");

`endif

[hdl/eqvt_pkg.sv]
// types, codes and defaults of the epoch quorum vote tracker
// no dependencies; used by every rtl file of the block
package eqvt_pkg;

   // default number of peer slots in the supporter bitmap
   localparam int unsigned PEER_SLOTS_DEFAULT = 64;

   // item actions
   localparam logic [1:0] ACT_PROPOSE = 2'd0;
   localparam logic [1:0] ACT_OBSERVE = 2'd1;
   localparam logic [1:0] ACT_EXPIRE  = 2'd2;

   // status codes
   localparam logic [1:0] ST_PENDING  = 2'd0;
   localparam logic [1:0] ST_MET      = 2'd1;
   localparam logic [1:0] ST_SPLIT    = 2'd2;
   localparam logic [1:0] ST_ISOLATED = 2'd3;

   // register indexes of the csr port
   localparam logic [1:0] CSR_LOCAL_PEER      = 2'd0;
   localparam logic [1:0] CSR_MINIMUM_QUORUM  = 2'd1;
   localparam logic [1:0] CSR_SAFETY_OVERRIDE = 2'd2;

   // proposal kind that stands for no proposal
   localparam logic [3:0] PROPOSAL_NONE = 4'd0;

   localparam logic [6:0] MINIMUM_QUORUM_RESET = 7'd1;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  proposal_kind;
      logic [63:0] epoch;
      logic [6:0]  requested_quorum;
      logic [5:0]  sender_peer;
      logic        is_consensus_packet;
      logic        sender_fresh;
      logic [63:0] fresh_mask;
      logic        split_isolated;
      logic        no_eligible_peers;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  supporter_count;
      logic        quorum_ok;
      logic        apply_action;
      logic [63:0] current_epoch;
   } rsp_payload_type;

   // tracked proposal state apart from the supporter bitmap
   typedef struct packed {
      logic [63:0] epoch;
      logic [3:0]  proposal;
      logic [6:0]  quorum;
      logic        met;
      logic [1:0]  status;
   } track_type;

   // configuration seen by the update logic
   typedef struct packed {
      logic [5:0] local_peer;
      logic [6:0] minimum_quorum;
      logic       safety_override;
   } cfg_type;

endpackage

[hdl/eqvt_next.sv]
// next-state and result logic for one item of the vote tracker
// depends on eqvt_pkg; purely combinational, sits between the item and result registers
module eqvt_next #(
   parameter int unsigned PEER_SLOTS = eqvt_pkg::PEER_SLOTS_DEFAULT
) (
   input  eqvt_pkg::req_payload_type item,
   input  eqvt_pkg::cfg_type         cfg,
   input  eqvt_pkg::track_type       cur_track,
   input  logic [PEER_SLOTS-1:0]     cur_bits,
   output eqvt_pkg::track_type       nxt_track,
   output logic [PEER_SLOTS-1:0]     nxt_bits,
   output eqvt_pkg::rsp_payload_type rsp
);

   localparam int unsigned CNT_W = $clog2(PEER_SLOTS + 1);

   logic [PEER_SLOTS-1:0] local_bit;
   logic [PEER_SLOTS-1:0] sender_bit;
   logic [6:0]            eff_min;
   logic [6:0]            need_new;
   logic [6:0]            need;
   logic                  newer;
   logic                  match;
   logic                  recompute;
   logic                  met;
   logic [CNT_W-1:0]      cnt;
   logic [6:0]            count;
   logic [63:0]           nxt_epoch;
   logic [3:0]            nxt_proposal;
   logic [6:0]            nxt_quorum;
   logic                  nxt_met;
   logic [1:0]            nxt_status;

   // one-hot peer decode, ids past the slot count have no bit
   always_comb begin
      for (int i = 0; i < PEER_SLOTS; i++) begin
         local_bit[i]  = (cfg.local_peer == 6'(i));
         sender_bit[i] = (item.sender_peer == 6'(i));
      end
   end

   // quorum floor, zero minimum acts as one
   assign eff_min  = (cfg.minimum_quorum == 7'd0) ? 7'd1 : cfg.minimum_quorum;
   assign need_new = (item.requested_quorum > eff_min) ? item.requested_quorum : eff_min;

   // observe epoch checks
   assign newer = item.epoch > cur_track.epoch;
   assign match = newer ||
                  ((item.epoch == cur_track.epoch) &&
                   (item.proposal_kind == cur_track.proposal));

   // bitmap and proposal update
   always_comb begin
      nxt_epoch    = cur_track.epoch;
      nxt_proposal = cur_track.proposal;
      nxt_quorum   = cur_track.quorum;
      nxt_bits     = cur_bits;
      recompute    = 1'b0;
      unique case (item.action)
         eqvt_pkg::ACT_PROPOSE: begin
            nxt_epoch    = item.epoch;
            nxt_proposal = item.proposal_kind;
            nxt_quorum   = need_new;
            nxt_bits     = local_bit;
            recompute    = 1'b1;
         end
         eqvt_pkg::ACT_OBSERVE: begin
            if (item.is_consensus_packet && item.sender_fresh) begin
               if (newer) begin
                  nxt_epoch    = item.epoch;
                  nxt_proposal = item.proposal_kind;
                  nxt_quorum   = need_new;
               end
               nxt_bits  = (newer ? '0 : cur_bits) | (match ? sender_bit : '0);
               recompute = 1'b1;
            end
         end
         eqvt_pkg::ACT_EXPIRE: begin
            nxt_bits  = cur_bits & (item.fresh_mask[PEER_SLOTS-1:0] | local_bit);
            recompute = 1'b1;
         end
         default: begin
            recompute = 1'b0;
         end
      endcase
   end

   // supporter popcount
   always_comb begin
      cnt = '0;
      for (int i = 0; i < PEER_SLOTS; i++) begin
         cnt = cnt + CNT_W'(nxt_bits[i]);
      end
   end
   assign count = 7'(cnt);

   // quorum compare against the effective quorum
   assign need = (nxt_quorum > eff_min) ? nxt_quorum : eff_min;
   assign met  = (count >= need);

   // met flag and status, held unless the item recomputes them
   always_comb begin
      nxt_met    = cur_track.met;
      nxt_status = cur_track.status;
      if (recompute) begin
         nxt_met = met;
         if (item.action == eqvt_pkg::ACT_EXPIRE) begin
            if (item.split_isolated)         nxt_status = eqvt_pkg::ST_SPLIT;
            else if (item.no_eligible_peers) nxt_status = eqvt_pkg::ST_ISOLATED;
            else if (met)                    nxt_status = eqvt_pkg::ST_MET;
            else                             nxt_status = eqvt_pkg::ST_PENDING;
         end else if (item.action == eqvt_pkg::ACT_OBSERVE) begin
            if (!met && item.split_isolated) nxt_status = eqvt_pkg::ST_SPLIT;
            else if (met)                    nxt_status = eqvt_pkg::ST_MET;
            else                             nxt_status = eqvt_pkg::ST_PENDING;
         end else begin
            nxt_status = met ? eqvt_pkg::ST_MET : eqvt_pkg::ST_PENDING;
         end
      end
   end

   // next tracked state
   assign nxt_track = {nxt_epoch, nxt_proposal, nxt_quorum, nxt_met, nxt_status};

   // result fields
   assign rsp.status          = nxt_status;
   assign rsp.supporter_count = count;
   assign rsp.quorum_ok       = nxt_met;
   assign rsp.apply_action    = !cfg.safety_override
                                && (nxt_proposal != eqvt_pkg::PROPOSAL_NONE) && nxt_met;
   assign rsp.current_epoch   = nxt_epoch;

endmodule

[hdl/epoch_quorum_vote_tracker.sv]
// top level of the epoch quorum vote tracker: item register, state, result register, csr
// depends on eqvt_pkg, eqvt_next and epoch_quorum_vote_tracker_macros.svh
//
// Each accepted item gives exactly one result; one item can be accepted every cycle while
// the result register is not held. An accepted item sits in the input register until the
// result register is free or taken; then the update logic (epoch compare, bitmap update,
// supporter popcount and quorum compare) writes the tracked state and the result
// register together. The result register holds its item while rsp_ready is low, and the
// input side keeps taking one more item meanwhile. Configuration writes through the csr
// port are taken in any cycle and act on items processed after them; met flag and status
// follow a new minimum quorum only at the next propose, accepted observe or expire item.
`include "epoch_quorum_vote_tracker_macros.svh"

module epoch_quorum_vote_tracker #(
   parameter int unsigned PEER_SLOTS = eqvt_pkg::PEER_SLOTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  eqvt_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output eqvt_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [6:0]                csr_wdata
);

   localparam int unsigned IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;

   eqvt_pkg::req_payload_type item_ff, item_in;
   logic                      item_valid_ff, item_valid_in;
   eqvt_pkg::rsp_payload_type rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   eqvt_pkg::track_type       track_ff, track_in;
   logic [PEER_SLOTS-1:0]     sup_bits_ff, sup_bits_in;
   eqvt_pkg::cfg_type         cfg_ff, cfg_in;
   logic                      advance;
   logic                      req_accept;
   logic                      local_in_slots;
   logic [IDX_W-1:0]          local_idx;

   // handshake control
   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !item_valid_ff || advance;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   assign item_valid_in = req_accept || (item_valid_ff && !advance);
   assign item_in       = req_accept ? req_payload : item_ff;
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp_ready);

   // update logic
   eqvt_next #(
      .PEER_SLOTS (PEER_SLOTS)
   ) u_next (
      .item      (item_ff),
      .cfg       (cfg_ff),
      .cur_track (track_ff),
      .cur_bits  (sup_bits_ff),
      .nxt_track (track_in),
      .nxt_bits  (sup_bits_in),
      .rsp       (rsp_in)
   );

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            eqvt_pkg::CSR_LOCAL_PEER:      cfg_in.local_peer      = csr_wdata[5:0];
            eqvt_pkg::CSR_MINIMUM_QUORUM:  cfg_in.minimum_quorum  = csr_wdata;
            eqvt_pkg::CSR_SAFETY_OVERRIDE: cfg_in.safety_override = csr_wdata[0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   // control state, configuration and tracked state
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff          <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         cfg_ff.local_peer      <= 6'd0;
         cfg_ff.minimum_quorum  <= eqvt_pkg::MINIMUM_QUORUM_RESET;
         cfg_ff.safety_override <= 1'b0;
         track_ff.epoch         <= 64'd0;
         track_ff.proposal      <= eqvt_pkg::PROPOSAL_NONE;
         track_ff.quorum        <= 7'd0;
         track_ff.met           <= 1'b0;
         track_ff.status        <= eqvt_pkg::ST_PENDING;
         sup_bits_ff            <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         cfg_ff        <= cfg_in;
         if (advance) begin
            track_ff    <= track_in;
            sup_bits_ff <= sup_bits_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // local peer lookup for checks
   assign local_in_slots = (7'(cfg_ff.local_peer) < 7'(PEER_SLOTS));
   assign local_idx      = IDX_W'(cfg_ff.local_peer);

   // a propose leaves the local peer as supporter when its id lies within the slots
   `EQVT_ASSERT_NEXT(a_propose_keeps_local, clock, reset, advance && (item_ff.action == eqvt_pkg::ACT_PROPOSE) && local_in_slots, sup_bits_ff[$past(local_idx)])
   // an observe never moves the tracked epoch backward
   `EQVT_ASSERT_NEXT(a_epoch_monotonic, clock, reset, advance && (item_ff.action == eqvt_pkg::ACT_OBSERVE), track_ff.epoch >= $past(track_ff.epoch))
   // collective action only with quorum met
   `EQVT_ASSERT(a_apply_needs_met, clock, reset, !(rsp_valid_ff && rsp_ff.apply_action) || rsp_ff.quorum_ok)
   // count stays within the slot range
   `EQVT_ASSERT(a_count_in_range, clock, reset, !rsp_valid_ff || (rsp_ff.supporter_count <= 7'(PEER_SLOTS)))

endmodule

[bench/epoch_quorum_vote_tracker_test.sv]
// self-checking bench for the epoch quorum vote tracker: directed table, then random phases
// depends on eqvt_pkg and epoch_quorum_vote_tracker; keeps its own tally of supporters
module epoch_quorum_vote_tracker_test;
   timeunit 1ns;
   timeprecision 1ps;

   // codes the package leaves out
   localparam logic [1:0]  ACT_UNUSED = 2'd3;
   localparam logic [1:0]  CSR_UNUSED = 2'd3;
   localparam logic [63:0] ALL_PEERS  = '1;
   localparam int          HOLD_CYCLES = 150;
   localparam int          PHASES = 6;
   localparam int          ITEMS_PER_PHASE = 100;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   eqvt_pkg::req_payload_type req_payload;
   logic                      rsp_valid;
   logic                      rsp_ready;
   eqvt_pkg::rsp_payload_type rsp_payload;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [1:0]                csr_index;
   logic [6:0]                csr_wdata;

   epoch_quorum_vote_tracker dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // one line of the directed plan: a register write or an item
   typedef struct {
      bit                        is_reg_write;
      logic [1:0]                reg_index;
      logic [6:0]                reg_value;
      eqvt_pkg::req_payload_type vote;
      bit                        has_fixed;
      eqvt_pkg::rsp_payload_type fixed_rsp;
   } plan_row_type;

   plan_row_type plan[$];

   // shadow configuration
   logic [5:0] local_peer_cfg = '0;
   logic [6:0] min_quorum_cfg = eqvt_pkg::MINIMUM_QUORUM_RESET;
   logic       override_cfg = 1'b0;

   // shadow tracker state
   logic [63:0] supporters = '0;
   logic [63:0] tr_epoch = '0;
   logic [3:0]  tr_proposal = eqvt_pkg::PROPOSAL_NONE;
   logic [6:0]  tr_quorum = '0;
   logic        tr_met = 1'b0;
   logic [1:0]  tr_status = eqvt_pkg::ST_PENDING;

   eqvt_pkg::rsp_payload_type pending_tallies[$];

   int  errors = 0;
   int  items_sent = 0;
   int  directed_items = 0;
   int  reg_writes = 0;
   int  results_seen = 0;
   bit  idle_on = 1'b1;
   bit  hold_done = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic eqvt_pkg::req_payload_type mk_req(input logic [1:0] act,
                                                        input logic [3:0] ptype,
                                                        input logic [63:0] ep,
                                                        input logic [6:0] rq,
                                                        input logic [5:0] snd,
                                                        input logic cons,
                                                        input logic fresh,
                                                        input logic [63:0] mask,
                                                        input logic split,
                                                        input logic noelig);
      eqvt_pkg::req_payload_type it;
      it.action = act;
      it.proposal_kind = ptype;
      it.epoch = ep;
      it.requested_quorum = rq;
      it.sender_peer = snd;
      it.is_consensus_packet = cons;
      it.sender_fresh = fresh;
      it.fresh_mask = mask;
      it.split_isolated = split;
      it.no_eligible_peers = noelig;
      return it;
   endfunction

   function automatic eqvt_pkg::rsp_payload_type mk_rsp(input logic [1:0] st,
                                                        input logic [6:0] cnt,
                                                        input logic met,
                                                        input logic apply,
                                                        input logic [63:0] ep);
      eqvt_pkg::rsp_payload_type r;
      r.status = st;
      r.supporter_count = cnt;
      r.quorum_ok = met;
      r.apply_action = apply;
      r.current_epoch = ep;
      return r;
   endfunction

   function automatic plan_row_type vote_row(input eqvt_pkg::req_payload_type it,
                                             input bit has_fixed,
                                             input eqvt_pkg::rsp_payload_type want);
      plan_row_type row;
      row.is_reg_write = 1'b0;
      row.reg_index = '0;
      row.reg_value = '0;
      row.vote = it;
      row.has_fixed = has_fixed;
      row.fixed_rsp = want;
      return row;
   endfunction

   function automatic plan_row_type reg_row(input logic [1:0] idx, input logic [6:0] val);
      plan_row_type row;
      row.is_reg_write = 1'b1;
      row.reg_index = idx;
      row.reg_value = val;
      row.vote = '0;
      row.has_fixed = 1'b0;
      row.fixed_rsp = '0;
      return row;
   endfunction

   // supporters against max(tracked quorum, floor)
   function automatic logic quorum_reached(input logic [6:0] min_floor);
      return $countones(supporters) >= ((tr_quorum > min_floor) ? tr_quorum : min_floor);
   endfunction

   // advance the shadow tracker by one item and return the result it owes
   function automatic eqvt_pkg::rsp_payload_type tally_vote(
         input eqvt_pkg::req_payload_type it);
      logic [6:0]                min_floor;
      eqvt_pkg::rsp_payload_type r;
      min_floor = (min_quorum_cfg == 0) ? 7'd1 : min_quorum_cfg;
      case (it.action)
         eqvt_pkg::ACT_PROPOSE: begin
            tr_proposal = it.proposal_kind;
            tr_epoch = it.epoch;
            tr_quorum = (it.requested_quorum > min_floor) ? it.requested_quorum : min_floor;
            supporters = 64'd1 << local_peer_cfg;
            tr_met = quorum_reached(min_floor);
            tr_status = tr_met ? eqvt_pkg::ST_MET : eqvt_pkg::ST_PENDING;
         end
         eqvt_pkg::ACT_OBSERVE: begin
            // rejected packets leave everything as is
            if (it.is_consensus_packet && it.sender_fresh) begin
               if (it.epoch > tr_epoch) begin
                  tr_proposal = it.proposal_kind;
                  tr_epoch = it.epoch;
                  tr_quorum = (it.requested_quorum > min_floor) ? it.requested_quorum
                                                                 : min_floor;
                  supporters = '0;
               end
               if (it.epoch == tr_epoch && it.proposal_kind == tr_proposal)
                  supporters[it.sender_peer] = 1'b1;
               tr_met = quorum_reached(min_floor);
               if (!tr_met && it.split_isolated)
                  tr_status = eqvt_pkg::ST_SPLIT;
               else
                  tr_status = tr_met ? eqvt_pkg::ST_MET : eqvt_pkg::ST_PENDING;
            end
         end
         eqvt_pkg::ACT_EXPIRE: begin
            // local peer survives any mask
            supporters &= it.fresh_mask | (64'd1 << local_peer_cfg);
            tr_met = quorum_reached(min_floor);
            if (it.split_isolated)
               tr_status = eqvt_pkg::ST_SPLIT;
            else if (it.no_eligible_peers)
               tr_status = eqvt_pkg::ST_ISOLATED;
            else
               tr_status = tr_met ? eqvt_pkg::ST_MET : eqvt_pkg::ST_PENDING;
         end
         default: ;
      endcase
      r.status = tr_status;
      r.supporter_count = 7'($countones(supporters));
      r.quorum_ok = tr_met;
      r.apply_action = !override_cfg && tr_proposal != eqvt_pkg::PROPOSAL_NONE && tr_met;
      r.current_epoch = tr_epoch;
      return r;
   endfunction

   // mostly well-formed traffic around the tracked proposal, some noise
   function automatic eqvt_pkg::req_payload_type random_vote_item();
      eqvt_pkg::req_payload_type it;
      int unsigned               pick;
      it = mk_req(2'($urandom), 4'($urandom), {$urandom, $urandom},
                  ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 6)),
                  6'($urandom), 1'($urandom), 1'($urandom), {$urandom, $urandom},
                  $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         it.action = eqvt_pkg::ACT_PROPOSE;
         if ($urandom_range(0, 3) != 0)
            it.epoch = tr_epoch + $urandom_range(1, 3);
      end else if (pick < 58) begin
         // vote for the tracked proposal
         it.action = eqvt_pkg::ACT_OBSERVE;
         it.epoch = tr_epoch;
         it.proposal_kind = tr_proposal;
         if ($urandom_range(0, 9) != 0) begin
            it.is_consensus_packet = 1'b1;
            it.sender_fresh = 1'b1;
         end
      end else if (pick < 66) begin
         // newer epoch takes over
         it.action = eqvt_pkg::ACT_OBSERVE;
         it.epoch = tr_epoch + $urandom_range(1, 3);
         it.is_consensus_packet = 1'b1;
         it.sender_fresh = 1'b1;
      end else if (pick < 72) begin
         it.action = eqvt_pkg::ACT_OBSERVE;
      end else if (pick < 90) begin
         // mostly fresh masks with a few stale peers
         it.action = eqvt_pkg::ACT_EXPIRE;
         if ($urandom_range(0, 2) != 0)
            it.fresh_mask = ~({$urandom, $urandom} & {$urandom, $urandom}
                              & {$urandom, $urandom});
      end else if (pick < 95) begin
         it.action = ACT_UNUSED;
      end
      return it;
   endfunction

   // offer one item, record its result on acceptance, maybe idle afterwards
   task automatic offer_item(input eqvt_pkg::req_payload_type it, input bit has_fixed,
                             input eqvt_pkg::rsp_payload_type want);
      eqvt_pkg::rsp_payload_type predicted;
      req_payload <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predicted = tally_vote(it);
      pending_tallies.push_back(has_fixed ? want : predicted);
      items_sent++;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
   endtask

   // register write once every result is back
   task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
      while (pending_tallies.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         eqvt_pkg::CSR_LOCAL_PEER:      local_peer_cfg = val[5:0];
         eqvt_pkg::CSR_MINIMUM_QUORUM:  min_quorum_cfg = val;
         eqvt_pkg::CSR_SAFETY_OVERRIDE: override_cfg = val[0];
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void field_check(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // result checker
   always @(posedge clock) begin : result_check
      eqvt_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_tallies.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp_payload);
         end else begin
            want = pending_tallies.pop_front();
            field_check("status", 64'(want.status), 64'(rsp_payload.status));
            field_check("supporter_count", 64'(want.supporter_count),
                        64'(rsp_payload.supporter_count));
            field_check("quorum_ok", 64'(want.quorum_ok), 64'(rsp_payload.quorum_ok));
            field_check("apply_action", 64'(want.apply_action),
                        64'(rsp_payload.apply_action));
            field_check("current_epoch", want.current_epoch, rsp_payload.current_epoch);
         end
      end
   end

   // receiver: random ready bursts, one long hold-off to back the block up
   initial begin
      int unsigned span;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && results_seen >= 250) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            span = $urandom_range(1, 16);
            rsp_ready <= !idle_on || ($urandom_range(0, 2) != 0);
            repeat (span) @(negedge clock);
         end
      end
   end

   // stimulus
   initial begin
      int drain;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;

      // directed plan, fixed expectations where they follow from the reset state
      plan.push_back(vote_row(mk_req(ACT_UNUSED, 4'hF, ALL_PEERS, 7'h7F, 6'h3F, 1, 1,
                                     ALL_PEERS, 1, 1), 1,
                              mk_rsp(eqvt_pkg::ST_PENDING, 0, 0, 0, 0)));
      // observes that are not consensus packets or come from stale senders
      plan.push_back(vote_row(mk_req(eqvt_pkg::ACT_OBSERVE, 4'h1, 64'd1, 7'd1, 6'd1, 0, 1,
                                     '0, 0, 0),
                              1, mk_rsp(eqvt_pkg::ST_PENDING, 0, 0, 0, 0)));
      plan.push_back(vote_row(mk_req(eqvt_pkg::ACT_OBSERVE, 4'h1, 64'd1, 7'd1, 6'd1, 1, 0,
                                     '0, 1, 0),
                              1, mk_rsp(eqvt_pkg::ST_PENDING, 0, 0, 0, 0)));
      // propose at the top epoch ignores isolation inputs
      plan.push_back(vote_row(mk_req(eqvt_pkg::ACT_PROPOSE, 4'hF, ALL_PEERS, 7'd0, 6'd0, 0, 0,
                                     '0, 1, 1),
                              1, mk_rsp(eqvt_pkg::ST_MET, 1, 1, 1, ALL_PEERS)));
      plan.push_back(vote_row(mk_req(eqvt_pkg::ACT_OBSERVE, 4'hF, ALL_PEERS, 7'd0, 6'd63,
                                     1, 1, '0, 1, 0),
                              1, mk_rsp(eqvt_pkg::ST_MET, 2, 1, 1, ALL_PEERS)));
      plan.push_back(vote_row(mk_req(eqvt_pkg::ACT_EXPIRE, 4'h0, '0, 7'd0, 6'd0, 0, 0,
                                     '0, 0, 1),
                              1, mk_rsp(eqvt_pkg::ST_ISOLATED, 1, 1, 1, ALL_PEERS)));
      plan.push_back(vote_row(mk_req(eqvt_pkg::ACT_EXPIRE, 4'h0, '0, 7'd0, 6'd0, 0, 0,
                                     ALL_PEERS, 1, 1),
                              1, mk_rsp(eqvt_pkg::ST_SPLIT, 1, 1, 1, ALL_PEERS)));
      // top peer id (upper wdata bit dropped) and a high floor
      plan.push_back(reg_row(eqvt_pkg::CSR_LOCAL_PEER, 7'h7F));
      plan.push_back(reg_row(eqvt_pkg::CSR_MINIMUM_QUORUM, 7'd64));
      plan.push_back(vote_row(mk_req(eqvt_pkg::ACT_PROPOSE, 4'h0, '0, 7'h7F, 6'd0, 0, 0,
                                     '0, 0, 0),
                              1, mk_rsp(eqvt_pkg::ST_PENDING, 1, 0, 0, 0)));
      plan.push_back(vote_row(mk_req(eqvt_pkg::ACT_OBSERVE, 4'h0, '0, 7'd0, 6'd0, 1, 1,
                                     '0, 1, 0),
                              1, mk_rsp(eqvt_pkg::ST_SPLIT, 2, 0, 0, 0)));
      plan.push_back(vote_row(mk_req(eqvt_pkg::ACT_OBSERVE, 4'h3, 64'd5, 7'd0, 6'd7, 1, 1,
                                     '0, 0, 0),
                              1, mk_rsp(eqvt_pkg::ST_PENDING, 1, 0, 0, 64'd5)));
      // zero floor acts as one; met flag stays stale until the next real update
      plan.push_back(reg_row(eqvt_pkg::CSR_MINIMUM_QUORUM, 7'd0));
      plan.push_back(vote_row(mk_req(ACT_UNUSED, 4'h0, '0, 7'd0, 6'd0, 0, 0, '0, 0, 0),
                              1, mk_rsp(eqvt_pkg::ST_PENDING, 1, 0, 0, 64'd5)));
      plan.push_back(vote_row(mk_req(eqvt_pkg::ACT_PROPOSE, 4'h3, 64'd9, 7'd0, 6'd0, 0, 0,
                                     '0, 0, 0),
                              1, mk_rsp(eqvt_pkg::ST_MET, 1, 1, 1, 64'd9)));
      plan.push_back(reg_row(eqvt_pkg::CSR_SAFETY_OVERRIDE, 7'd1));
      plan.push_back(vote_row(mk_req(ACT_UNUSED, 4'h0, '0, 7'd0, 6'd0, 1, 1, '0, 0, 0),
                              1, mk_rsp(eqvt_pkg::ST_MET, 1, 1, 0, 64'd9)));
      plan.push_back(vote_row(mk_req(eqvt_pkg::ACT_OBSERVE, 4'h3, 64'd2, 7'd0, 6'd1, 1, 1,
                                     '0, 0, 0),
                              0, '0));
      plan.push_back(vote_row(mk_req(eqvt_pkg::ACT_EXPIRE, 4'h0, '0, 7'd0, 6'd0, 0, 0,
                                     64'h7FFF_FFFF_FFFF_FFFF, 0, 0), 0, '0));
      plan.push_back(reg_row(CSR_UNUSED, 7'h55));
      plan.push_back(reg_row(eqvt_pkg::CSR_SAFETY_OVERRIDE, 7'd0));
      plan.push_back(reg_row(eqvt_pkg::CSR_MINIMUM_QUORUM, 7'd2));
      plan.push_back(vote_row(mk_req(ACT_UNUSED, 4'h0, '0, 7'd0, 6'd0, 0, 0, '0, 0, 0),
                              0, '0));
      plan.push_back(vote_row(mk_req(eqvt_pkg::ACT_OBSERVE, 4'h3, 64'd9, 7'd0, 6'd62, 1, 1,
                                     '0, 0, 0),
                              0, '0));
      plan.push_back(vote_row(mk_req(eqvt_pkg::ACT_OBSERVE, 4'h4, 64'd9, 7'd0, 6'd5, 1, 1,
                                     '0, 0, 0),
                              0, '0));
      plan.push_back(vote_row(mk_req(eqvt_pkg::ACT_EXPIRE, 4'h0, '0, 7'd0, 6'd0, 0, 0,
                                     '0, 0, 0),
                              0, '0));

      // reset
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // walk the directed plan
      foreach (plan[i]) begin
         if (plan[i].is_reg_write) begin
            req_valid <= 1'b0;
            write_reg(plan[i].reg_index, plan[i].reg_value);
         end else begin
            offer_item(plan[i].vote, plan[i].has_fixed, plan[i].fixed_rsp);
         end
      end
      directed_items = items_sent;

      // random phases, each under fresh settings; the last one without idling
      for (int phase = 0; phase < PHASES; phase++) begin
         idle_on = (phase != PHASES - 1);
         req_valid <= 1'b0;
         write_reg(eqvt_pkg::CSR_LOCAL_PEER, 7'($urandom));
         write_reg(eqvt_pkg::CSR_MINIMUM_QUORUM,
                   ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(1, 4)));
         write_reg(eqvt_pkg::CSR_SAFETY_OVERRIDE, 7'($urandom_range(0, 2) == 0));
         repeat (ITEMS_PER_PHASE) offer_item(random_vote_item(), 1'b0, '0);
      end
      req_valid <= 1'b0;

      // drain
      drain = 0;
      while (pending_tallies.size() != 0 && drain < 2000) begin
         @(posedge clock);
         drain++;
      end
      if (pending_tallies.size() != 0) begin
         errors += pending_tallies.size();
         $display("%0t: %0d results never arrived", $time, pending_tallies.size());
      end
      repeat (10) @(posedge clock);

      $display("covered %0d items (%0d from the directed table), %0d results, %0d reg writes",
               items_sent, directed_items, results_seen, reg_writes);
      $display("output hold-off of %0d cycles done: %0d, mismatches: %0d",
               HOLD_CYCLES, hold_done, errors);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
